>>> hdl/spira_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spira_pkg: shared types and constants of the spi register access slave
// Item kinds, protocol phases, the result record and the field widths.
// ----------------------------------------------------------------------------
package spira_pkg;

	// fixed field widths of the stream items
	localparam int ADDR_W   = 15;
	localparam int WORD_W   = 16;
	localparam int PAD_W    = 4;
	localparam int KIND_W   = 2;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 88;
	localparam int CFG_IDX_W = 1;

	// register reset values
	localparam logic [ADDR_W-1:0] PAD_START_RESET = 15'h0110;
	localparam logic [PAD_W-1:0]  PAD_COUNT_RESET = 4'd5;

	// bit 15 of the address word marks a read
	localparam int READ_FLAG_BIT = 15;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_COUNT = 1'b1;

	// what an input item stands for
	typedef enum logic [KIND_W-1:0] {
		KIND_RX      = 2'd0,
		KIND_SLOT    = 2'd1,
		KIND_RELEASE = 2'd2
	} kind_t;

	// protocol phase of the current operation
	typedef enum logic [1:0] {
		PH_ADDR  = 2'd0,
		PH_WRITE = 2'd1,
		PH_READ  = 2'd2
	} phase_t;

	// one result item
	typedef struct packed {
		logic              end_valid;
		logic              start_is_read;
		logic [ADDR_W-1:0] start_address;
		logic              start_valid;
		logic [ADDR_W-1:0] read_address;
		logic              read_valid;
		logic [WORD_W-1:0] write_data;
		logic [ADDR_W-1:0] write_address;
		logic              write_valid;
		logic [WORD_W-1:0] tx_word;
		logic              tx_valid;
	} result_t;

endpackage

>>> hdl/spira_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spira_engine: protocol state and per-item decode
// Holds phase, pad counters and pointers; builds the result for one item.
// ----------------------------------------------------------------------------
module spira_engine #(
	parameter int ADDRESS_BITS = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  spira_pkg::kind_t                 kind,
	input  logic [spira_pkg::WORD_W-1:0]     rx_word,
	input  logic [spira_pkg::WORD_W-1:0]     read_data,
	input  logic [spira_pkg::ADDR_W-1:0]     pad_start_address,
	input  logic [spira_pkg::PAD_W-1:0]      pad_word_count,
	output spira_pkg::result_t               result
);

	spira_pkg::phase_t            phase_q, phase_d;
	logic [spira_pkg::PAD_W-1:0]  rx_pad_q, rx_pad_d;
	logic [spira_pkg::PAD_W-1:0]  tx_pad_q, tx_pad_d;
	logic [ADDRESS_BITS-1:0]      wr_ptr_q, wr_ptr_d;
	logic [ADDRESS_BITS-1:0]      rd_ptr_q, rd_ptr_d;
	logic [ADDRESS_BITS-1:0]      addr;
	logic                         pad_hit;
	logic                         in_op;

	// address field of a received word and pad decision
	assign addr    = rx_word[ADDRESS_BITS-1:0];
	assign pad_hit = spira_pkg::ADDR_W'(addr) >= pad_start_address;
	assign in_op   = (phase_q == spira_pkg::PH_WRITE) || (phase_q == spira_pkg::PH_READ);

	// next state
	always_comb begin
		phase_d  = phase_q;
		rx_pad_d = rx_pad_q;
		tx_pad_d = tx_pad_q;
		wr_ptr_d = wr_ptr_q;
		rd_ptr_d = rd_ptr_q;
		case (kind)
			spira_pkg::KIND_RX: begin
				if (phase_q == spira_pkg::PH_WRITE) begin
					if (rx_pad_q != '0) begin
						rx_pad_d = rx_pad_q - 1'b1;
					end else begin
						wr_ptr_d = wr_ptr_q + 1'b1;
					end
				end else if (phase_q != spira_pkg::PH_READ) begin
					if (pad_hit) begin
						rx_pad_d = pad_word_count;
						tx_pad_d = (pad_word_count != '0) ? pad_word_count - 1'b1 : '0;
					end
					wr_ptr_d = addr;
					rd_ptr_d = addr;
					phase_d  = rx_word[spira_pkg::READ_FLAG_BIT] ? spira_pkg::PH_READ
					                                             : spira_pkg::PH_WRITE;
				end
			end
			spira_pkg::KIND_SLOT: begin
				if (in_op) begin
					if (tx_pad_q != '0) begin
						tx_pad_d = tx_pad_q - 1'b1;
					end else begin
						rd_ptr_d = rd_ptr_q + 1'b1;
					end
				end
			end
			spira_pkg::KIND_RELEASE: begin
				phase_d  = spira_pkg::PH_ADDR;
				rx_pad_d = '0;
				tx_pad_d = '0;
				wr_ptr_d = '0;
				rd_ptr_d = '0;
			end
			default: begin
			end
		endcase
	end

	// result of the item
	always_comb begin
		result = '0;
		case (kind)
			spira_pkg::KIND_RX: begin
				if (phase_q == spira_pkg::PH_WRITE) begin
					if (rx_pad_q == '0) begin
						result.write_valid   = 1'b1;
						result.write_address = spira_pkg::ADDR_W'(wr_ptr_q);
						result.write_data    = rx_word;
					end
				end else if (phase_q != spira_pkg::PH_READ) begin
					result.start_valid   = 1'b1;
					result.start_address = spira_pkg::ADDR_W'(addr);
					result.start_is_read = rx_word[spira_pkg::READ_FLAG_BIT];
				end
			end
			spira_pkg::KIND_SLOT: begin
				result.tx_valid = 1'b1;
				if (in_op) begin
					if (tx_pad_q != '0) begin
						result.tx_word = spira_pkg::WORD_W'(tx_pad_q);
					end else begin
						result.tx_word      = read_data;
						result.read_valid   = 1'b1;
						result.read_address = spira_pkg::ADDR_W'(rd_ptr_q);
					end
				end
			end
			spira_pkg::KIND_RELEASE: begin
				result.end_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= spira_pkg::PH_ADDR;
			rx_pad_q <= '0;
			tx_pad_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			rx_pad_q <= rx_pad_d;
			tx_pad_q <= tx_pad_d;
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
		end
	end

endmodule

>>> hdl/spi_register_access_slave_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_register_access_slave_core: word-level spi slave for register access
// Decodes address, pad, write and read words of a 16-bit spi register link.
//
// channel  direction  payload
// s_*      in         tuser: kind[1:0]; tdata: rx_word[15:0], read_data[31:16]
// m_*      out        tdata: result record, see port comment
// cfg_*    in         cfg_index 0 pad_start_address, 1 pad_word_count
//
// one item per cycle while m_tready is high; input stage, then result stage
// the protocol state advances in the result stage, one step per item
// reset clears phase, pad counters and pointers; registers return to 272 and 5
// m_tready low holds the result; s_tready drops only when both stages are full
// ----------------------------------------------------------------------------
module spi_register_access_slave_core #(
	parameter int ADDRESS_BITS = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// rx_word[15:0], read_data[31:16]
	input  logic [spira_pkg::IN_W-1:0]          s_tdata,
	// kind[1:0]
	input  logic [spira_pkg::KIND_W-1:0]        s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tx_valid[0], tx_word[16:1], write_valid[17], write_address[32:18],
	// write_data[48:33], read_valid[49], read_address[64:50], start_valid[65],
	// start_address[80:66], start_is_read[81], end_valid[82], zero[87:83]
	output logic [spira_pkg::OUT_W-1:0]         m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [spira_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spira_pkg::ADDR_W-1:0]        cfg_data
);

	logic                          valid_s1;
	spira_pkg::kind_t              kind_s1;
	logic [spira_pkg::WORD_W-1:0]  rx_word_s1;
	logic [spira_pkg::WORD_W-1:0]  read_data_s1;
	logic                          valid_s2;
	spira_pkg::result_t            result_s2;
	spira_pkg::result_t            result;
	logic [spira_pkg::ADDR_W-1:0]  pad_start_q;
	logic [spira_pkg::PAD_W-1:0]   pad_count_q;
	logic                          advance;
	logic                          fire;

	// handshake
	assign advance   = !valid_s2 || m_tready;
	assign fire      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_start_q <= spira_pkg::PAD_START_RESET;
			pad_count_q <= spira_pkg::PAD_COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				spira_pkg::CFG_PAD_START: pad_start_q <= cfg_data;
				spira_pkg::CFG_PAD_COUNT: pad_count_q <= cfg_data[spira_pkg::PAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1      <= spira_pkg::kind_t'(s_tuser);
			rx_word_s1   <= s_tdata[spira_pkg::WORD_W-1:0];
			read_data_s1 <= s_tdata[spira_pkg::IN_W-1:spira_pkg::WORD_W];
		end
	end

	// protocol decode
	spira_engine #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.kind             (kind_s1),
		.rx_word          (rx_word_s1),
		.read_data        (read_data_s1),
		.pad_start_address(pad_start_q),
		.pad_word_count   (pad_count_q),
		.result           (result)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, result_s2};

	// a result carries at most one kind of event
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({result_s2.tx_valid, result_s2.write_valid,
			result_s2.start_valid, result_s2.end_valid}))
		else $error("result carries more than one event");

	// a release item yields an end result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (kind_s1 == spira_pkg::KIND_RELEASE) |=> valid_s2 && result_s2.end_valid)
		else $error("release item did not produce end result");

	// a read is only reported with a transmit word
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.read_valid |-> result_s2.tx_valid)
		else $error("read reported without transmit slot");

	// both stages full and output stalled blocks new input
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |-> !s_tready)
		else $error("input accepted while pipeline full");

endmodule
